FILE: rtl/core/cssr_pkg.sv
// Shared types and constants for the cyclic shift rank select block.
package cssr_pkg;

  localparam logic [6:0] CODE_LOW = 7'd32;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  char_code;
    logic        last_char;
    logic [10:0] rank_wanted;
  } in_t;

  typedef struct packed {
    logic [9:0] start_pos;
    logic       found;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QUERY,
    S_CLR,
    S_CCNT,
    S_PFX,
    S_CPLACE,
    S_CCLS,
    S_DSH,
    S_DCNT,
    S_DPLACE,
    S_DCLS,
    S_DCPY,
    S_FIRST
  } state_e;

endpackage

FILE: rtl/core/cssr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cssr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/cyclic_shift_rank_select.sv
// Top level of the cyclic shift rank select block.
//
// Load items (req_type 0) write one character each, one item per cycle
// while the block is idle and holds no untaken result; codes are clamped
// into the alphabet, characters past MAX_LEN are dropped, and the item with
// last_char set starts the sort of all cyclic shifts. The first load after
// a finished sort starts a new string. The sort is prefix doubling run by a
// sequencer over single-port-read memories (text, class, order, shifted
// order, new class, bucket), one element at a time because every memory
// read is registered. It runs a character pass, ceil(log2 n) doubling
// passes for n characters, and a pass that builds the rank to position
// table; no item is taken meanwhile. A query item (req_type 1) reads that
// table and registers one result item; the next item is taken once the
// result has been taken.
module cyclic_shift_rank_select #(
  parameter int unsigned MAX_LEN       = 1024,
  parameter int unsigned ALPHABET_SIZE = 95
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cssr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cssr_pkg::out_t out_data_o
);
  import cssr_pkg::*;

  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned TW  = $clog2(ALPHABET_SIZE);
  localparam int unsigned BD  = (MAX_LEN > ALPHABET_SIZE) ? MAX_LEN : ALPHABET_SIZE;
  localparam int unsigned BAW = $clog2(BD);

  // Memory ports.
  logic t_we; logic [AW-1:0] t_wa, t_ra; logic [TW-1:0] t_wd, t_rd;
  logic c_we; logic [AW-1:0] c_wa, c_ra, c_wd, c_rd;
  logic o_we; logic [AW-1:0] o_wa, o_ra, o_wd, o_rd;
  logic s_we; logic [AW-1:0] s_wa, s_ra, s_wd, s_rd;
  logic n_we; logic [AW-1:0] n_wa, n_ra, n_wd, n_rd;
  logic b_we; logic [BAW-1:0] b_wa, b_ra; logic [CW-1:0] b_wd, b_rd;

  cssr_ram #(.Width(TW), .Depth(MAX_LEN)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));
  cssr_ram #(.Width(AW), .Depth(MAX_LEN)) u_class (
    .clk_i, .we_i(c_we), .waddr_i(c_wa), .wdata_i(c_wd), .raddr_i(c_ra), .rdata_o(c_rd));
  cssr_ram #(.Width(AW), .Depth(MAX_LEN)) u_order (
    .clk_i, .we_i(o_we), .waddr_i(o_wa), .wdata_i(o_wd), .raddr_i(o_ra), .rdata_o(o_rd));
  // Holds the shifted order while sorting, then the rank to position table.
  cssr_ram #(.Width(AW), .Depth(MAX_LEN)) u_shift (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));
  cssr_ram #(.Width(AW), .Depth(MAX_LEN)) u_nclass (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(n_ra), .rdata_o(n_rd));
  cssr_ram #(.Width(CW), .Depth(BD)) u_bucket (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd));

  // Sequencer state.
  state_e         state_q, state_d;
  logic [1:0]     ph_q, ph_d;
  logic [CW-1:0]  i_q, i_d;
  logic [CW-1:0]  n_q, n_d;          // text length
  logic [CW-1:0]  ccount_q, ccount_d; // class count of the finished sort
  logic [CW-1:0]  cnt_q, cnt_d;      // classes of the current pass
  logic [CW-1:0]  nb_q, nb_d;        // buckets in use
  logic [AW-1:0]  nc_q, nc_d;
  logic [SW-1:0]  step_q, step_d;
  logic [CW-1:0]  sum_q, sum_d;
  logic [BAW-1:0] key_q, key_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [TW-1:0]  prev_q, prev_d;
  logic [AW-1:0]  pf_q, pf_d, ps_q, ps_d, f_q, f_d;
  logic           first_q, first_d;
  logic           hit_q, hit_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;

  // Combinational helpers.
  logic          last_i, last_b;
  logic [CW-1:0] len_base;
  logic [8:0]    off;
  logic [TW-1:0] code_off;
  logic [SW-1:0] ord_x, shifted, wrap_sum, wrap;
  logic [AW-1:0] nc_next;
  logic          rank_ok;

  assign last_i = (i_q == n_q - CW'(1));
  assign last_b = (i_q == nb_q - CW'(1));
  assign len_base = (ccount_q != '0) ? '0 : n_q;
  assign off = 9'(in_data_i.char_code) - 9'(CODE_LOW);
  assign code_off = (in_data_i.char_code < CODE_LOW) ? '0 :
                    (off > 9'(ALPHABET_SIZE - 1)) ? TW'(ALPHABET_SIZE - 1) : TW'(off);
  assign ord_x = SW'(o_rd);
  assign shifted = (ord_x >= step_q) ? ord_x - step_q : ord_x + SW'(n_q) - step_q;
  assign wrap_sum = SW'(pos_q) + step_q;
  assign wrap = (wrap_sum >= SW'(n_q)) ? wrap_sum - SW'(n_q) : wrap_sum;
  assign rank_ok = (ccount_q != '0) && (in_data_i.rank_wanted != '0) &&
                   (32'(in_data_i.rank_wanted) <= 32'(ccount_q));

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ph_q        <= '0;
      i_q         <= '0;
      n_q         <= '0;
      ccount_q    <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      i_q         <= i_d;
      n_q         <= n_d;
      ccount_q    <= ccount_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    nb_q   <= nb_d;
    nc_q   <= nc_d;
    step_q <= step_d;
    sum_q  <= sum_d;
    key_q  <= key_d;
    pos_q  <= pos_d;
    prev_q <= prev_d;
    pf_q   <= pf_d;
    ps_q   <= ps_d;
    f_q    <= f_d;
    hit_q  <= hit_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d = state_q; ph_d = ph_q; i_d = i_q; n_d = n_q; ccount_d = ccount_q;
    cnt_d = cnt_q; nb_d = nb_q; nc_d = nc_q; step_d = step_q; sum_d = sum_q;
    key_d = key_q; pos_d = pos_q; prev_d = prev_q; pf_d = pf_q; ps_d = ps_q;
    f_d = f_q; first_d = first_q; hit_d = hit_q; out_valid_d = out_valid_q;
    out_d = out_q; nc_next = nc_q;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
    b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          if (in_data_i.req_type == REQ_LOAD) begin
            // A load after a finished sort starts a new string.
            ccount_d = '0;
            n_d = len_base;
            if (32'(len_base) < 32'(MAX_LEN)) begin
              t_we = 1'b1;
              t_wa = AW'(len_base);
              t_wd = code_off;
              n_d  = len_base + CW'(1);
            end
            if (in_data_i.last_char) begin
              state_d = S_CLR;
              first_d = 1'b1;
              nb_d    = CW'(ALPHABET_SIZE);
              i_d     = '0;
              ph_d    = '0;
            end
          end else begin
            s_ra    = AW'(in_data_i.rank_wanted - 11'd1);
            hit_d   = rank_ok;
            state_d = S_QUERY;
          end
        end
      end

      S_QUERY: begin
        out_valid_d     = 1'b1;
        out_d.found     = hit_q;
        out_d.start_pos = hit_q ? 10'(s_rd) : '0;
        state_d         = S_IDLE;
      end

      // Clear the buckets in use.
      S_CLR: begin
        b_we = 1'b1;
        b_wa = BAW'(i_q);
        if (last_b) begin
          i_d = '0;
          state_d = first_q ? S_CCNT : S_DCNT;
        end else begin
          i_d = i_q + CW'(1);
        end
      end

      S_CCNT: begin
        case (ph_q)
          2'd0: begin t_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin b_ra = BAW'(t_rd); key_d = BAW'(t_rd); ph_d = 2'd2; end
          default: begin
            b_we = 1'b1; b_wa = key_q; b_wd = b_rd + CW'(1);
            ph_d = 2'd0;
            if (last_i) begin
              i_d = '0; sum_d = '0; state_d = S_PFX;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      // Turn counts into starting offsets.
      S_PFX: begin
        if (ph_q == 2'd0) begin
          b_ra = BAW'(i_q); ph_d = 2'd1;
        end else begin
          b_we = 1'b1; b_wa = BAW'(i_q); b_wd = sum_q;
          sum_d = sum_q + b_rd;
          ph_d = 2'd0;
          if (last_b) begin
            i_d = '0;
            state_d = first_q ? S_CPLACE : S_DPLACE;
          end else begin
            i_d = i_q + CW'(1);
          end
        end
      end

      S_CPLACE: begin
        case (ph_q)
          2'd0: begin t_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin b_ra = BAW'(t_rd); key_d = BAW'(t_rd); ph_d = 2'd2; end
          default: begin
            o_we = 1'b1; o_wa = AW'(b_rd); o_wd = AW'(i_q);
            b_we = 1'b1; b_wa = key_q; b_wd = b_rd + CW'(1);
            ph_d = 2'd0;
            if (last_i) begin
              i_d = '0; nc_d = '0; state_d = S_CCLS;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      S_CCLS: begin
        case (ph_q)
          2'd0: begin o_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin t_ra = o_rd; pos_d = o_rd; ph_d = 2'd2; end
          default: begin
            nc_next = ((i_q != '0) && (t_rd != prev_q)) ? nc_q + AW'(1) : nc_q;
            c_we = 1'b1; c_wa = pos_q; c_wd = nc_next;
            prev_d = t_rd; nc_d = nc_next;
            ph_d = 2'd0;
            if (last_i) begin
              cnt_d   = CW'(nc_next) + CW'(1);
              first_d = 1'b0;
              step_d  = SW'(1);
              if (n_q > CW'(1)) begin
                i_d = '0; state_d = S_DSH;
              end else begin
                i_d = n_q - CW'(1); state_d = S_FIRST;
              end
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      // Step every start back by the half length.
      S_DSH: begin
        if (ph_q == 2'd0) begin
          o_ra = AW'(i_q); ph_d = 2'd1;
        end else begin
          s_we = 1'b1; s_wa = AW'(i_q); s_wd = AW'(shifted);
          ph_d = 2'd0;
          if (last_i) begin
            i_d = '0; nb_d = cnt_q; state_d = S_CLR;
          end else begin
            i_d = i_q + CW'(1);
          end
        end
      end

      S_DCNT: begin
        case (ph_q)
          2'd0: begin s_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin c_ra = s_rd; ph_d = 2'd2; end
          2'd2: begin b_ra = BAW'(c_rd); key_d = BAW'(c_rd); ph_d = 2'd3; end
          default: begin
            b_we = 1'b1; b_wa = key_q; b_wd = b_rd + CW'(1);
            ph_d = 2'd0;
            if (last_i) begin
              i_d = '0; sum_d = '0; state_d = S_PFX;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      S_DPLACE: begin
        case (ph_q)
          2'd0: begin s_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin c_ra = s_rd; pos_d = s_rd; ph_d = 2'd2; end
          2'd2: begin b_ra = BAW'(c_rd); key_d = BAW'(c_rd); ph_d = 2'd3; end
          default: begin
            o_we = 1'b1; o_wa = AW'(b_rd); o_wd = pos_q;
            b_we = 1'b1; b_wa = key_q; b_wd = b_rd + CW'(1);
            ph_d = 2'd0;
            if (last_i) begin
              i_d = '0; nc_d = '0; state_d = S_DCLS;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      // Assign dense classes from the first and second half classes.
      S_DCLS: begin
        case (ph_q)
          2'd0: begin o_ra = AW'(i_q); ph_d = 2'd1; end
          2'd1: begin c_ra = o_rd; pos_d = o_rd; ph_d = 2'd2; end
          2'd2: begin c_ra = AW'(wrap); f_d = c_rd; ph_d = 2'd3; end
          default: begin
            nc_next = ((i_q != '0) && ((f_q != pf_q) || (c_rd != ps_q))) ?
                      nc_q + AW'(1) : nc_q;
            n_we = 1'b1; n_wa = pos_q; n_wd = nc_next;
            pf_d = f_q; ps_d = c_rd; nc_d = nc_next;
            ph_d = 2'd0;
            if (last_i) begin
              i_d = '0; cnt_d = CW'(nc_next) + CW'(1); state_d = S_DCPY;
            end else begin
              i_d = i_q + CW'(1);
            end
          end
        endcase
      end

      S_DCPY: begin
        if (ph_q == 2'd0) begin
          n_ra = AW'(i_q); ph_d = 2'd1;
        end else begin
          c_we = 1'b1; c_wa = AW'(i_q); c_wd = n_rd;
          ph_d = 2'd0;
          if (last_i) begin
            step_d = step_q << 1;
            if ((step_q << 1) < SW'(n_q)) begin
              i_d = '0; state_d = S_DSH;
            end else begin
              i_d = n_q - CW'(1); state_d = S_FIRST;
            end
          end else begin
            i_d = i_q + CW'(1);
          end
        end
      end

      // Walk positions downward so the smallest start of each class wins.
      S_FIRST: begin
        if (ph_q == 2'd0) begin
          c_ra = AW'(i_q); ph_d = 2'd1;
        end else begin
          s_we = 1'b1; s_wa = c_rd; s_wd = AW'(i_q);
          ph_d = 2'd0;
          if (i_q == '0) begin
            ccount_d = cnt_q; state_d = S_IDLE;
          end else begin
            i_d = i_q - CW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
